/* hw/rtl/dcdds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcdds_pkg
// Shared types and constants of the two-channel DDS burst source.
// ----------------------------------------------------------------------------
package dcdds_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int PHASE_BITS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [15:0] CMD_A = 16'h3000;
	localparam logic [15:0] CMD_B = 16'hB000;

	localparam logic [11:0] IDLE_A_RST = 12'd1996;
	localparam logic [11:0] IDLE_B_RST = 12'd2010;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RUN   = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_INC   = 3'd0,
		REG_BURST_EN    = 3'd1,
		REG_BURST_CH    = 3'd2,
		REG_BURST_TICKS = 3'd3,
		REG_IDLE_A      = 3'd4,
		REG_IDLE_B      = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        table_channel;
		logic [11:0] table_index;
		logic [11:0] table_value;
	} dds_cmd_t;

	typedef struct packed {
		logic [15:0] dac_word;
		logic        dac_channel;
		logic        last;
	} dds_dac_t;

endpackage
`default_nettype wire

/* hw/rtl/dual_channel_dds_burst.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_dds_burst
// Two-channel DDS source: phase accumulator, two sample tables, DAC words.
// ----------------------------------------------------------------------------
// A command is taken in every cycle as long as the output side keeps up. A
// tick or stop that yields two DAC words (A then B) fills both output buffer
// registers, and commands behind continuous ticks stall while a pair drains;
// burst ticks, table writes and run commands run at one per cycle when no pair
// drains. The first word passes stage 1 (registered table read), then the output
// register. The tables are not cleared at reset: an entry that was never written
// reads back as garbage. Phase index is the top log2(TABLE_DEPTH) phase bits.
// ----------------------------------------------------------------------------
module dual_channel_dds_burst #(
	parameter int TABLE_DEPTH = dcdds_pkg::TABLE_DEPTH_DEF,
	parameter int PHASE_BITS  = dcdds_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS = dcdds_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cmd_valid,
	output logic                                  cmd_stall,
	input  dcdds_pkg::dds_cmd_t                   cmd,
	output logic                                  dac_valid,
	input  wire                                   dac_stall,
	output dcdds_pkg::dds_dac_t                   dac,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [dcdds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire [dcdds_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	import dcdds_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int IDXW = (AW > 12) ? AW : 12;

	typedef enum logic [2:0] {
		KIND_STOP  = 3'b001,
		KIND_BURST = 3'b010,
		KIND_CONT  = 3'b100
	} kind_t;

	// configuration registers
	logic [31:0] phase_inc_q;
	logic        burst_en_q;
	logic        burst_ch_q;
	logic [15:0] burst_ticks_q;
	logic [11:0] idle_a_q;
	logic [11:0] idle_b_q;

	// running state
	logic [PHASE_BITS-1:0] phase_q;
	logic                  running_q;
	logic [15:0]           ticks_q;

	// stage 1 and output buffer
	logic     valid_s1;
	kind_t    kind_s1;
	logic     ch_s1;
	dds_dac_t dac_q;
	dds_dac_t nxt_q;
	logic     dac_valid_q;
	logic     nxt_valid_q;

	logic                  cmd_acc;
	logic                  dac_acc;
	logic                  buf_free;
	logic                  s1_load;
	logic [PHASE_BITS-1:0] phase_next;
	logic [AW-1:0]         rd_addr;
	logic [IDXW-1:0]       wr_idx;
	logic                  wr_en_a;
	logic                  wr_en_b;
	logic                  in_range;
	logic [SAMPLE_BITS-1:0] wr_sample;
	logic [SAMPLE_BITS-1:0] rd_a;
	logic [SAMPLE_BITS-1:0] rd_b;
	logic                  do_tick;
	logic [15:0]           ticks_dec;
	dds_dac_t              w0;
	dds_dac_t              w1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q   <= '0;
			burst_en_q    <= 1'b0;
			burst_ch_q    <= 1'b0;
			burst_ticks_q <= '0;
			idle_a_q      <= IDLE_A_RST;
			idle_b_q      <= IDLE_B_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PHASE_INC:   phase_inc_q   <= cfg_data;
				REG_BURST_EN:    burst_en_q    <= cfg_data[0];
				REG_BURST_CH:    burst_ch_q    <= cfg_data[0];
				REG_BURST_TICKS: burst_ticks_q <= cfg_data[15:0];
				REG_IDLE_A:      idle_a_q      <= cfg_data[11:0];
				REG_IDLE_B:      idle_b_q      <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign dac_acc   = dac_valid_q && !dac_stall;
	assign buf_free  = !dac_valid_q || (dac_acc && !nxt_valid_q);
	assign cmd_stall = valid_s1 && !buf_free;
	assign cmd_acc   = cmd_valid && !cmd_stall;

	assign phase_next = phase_q + PHASE_BITS'(phase_inc_q);
	assign rd_addr    = phase_next[PHASE_BITS-1 -: AW];
	assign ticks_dec  = ticks_q - 16'd1;

	// a tick that steps the phase and reads the tables
	assign do_tick = cmd_acc && (op_t'(cmd.op) == OP_TICK) && running_q &&
		(!burst_en_q || (ticks_q != 16'd0));

	// commands that leave words in stage 1
	assign s1_load = do_tick || (cmd_acc && (op_t'(cmd.op) == OP_STOP));

	assign wr_idx    = IDXW'(cmd.table_index);
	assign in_range  = 32'(cmd.table_index) < 32'(TABLE_DEPTH);
	assign wr_sample = SAMPLE_BITS'(cmd.table_value);
	assign wr_en_a   = cmd_acc && (op_t'(cmd.op) == OP_WRITE) && in_range &&
		!cmd.table_channel;
	assign wr_en_b   = cmd_acc && (op_t'(cmd.op) == OP_WRITE) && in_range &&
		cmd.table_channel;

	dcdds_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_DEPTH)) u_table_a (
		.clk     (clk),
		.wr_en   (wr_en_a),
		.wr_addr (wr_idx[AW-1:0]),
		.wr_data (wr_sample),
		.rd_en   (do_tick),
		.rd_addr (rd_addr),
		.rd_data (rd_a)
	);

	dcdds_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_DEPTH)) u_table_b (
		.clk     (clk),
		.wr_en   (wr_en_b),
		.wr_addr (wr_idx[AW-1:0]),
		.wr_data (wr_sample),
		.rd_en   (do_tick),
		.rd_addr (rd_addr),
		.rd_data (rd_b)
	);

	// command decode, state update, stage 1 load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			running_q <= 1'b0;
			ticks_q   <= '0;
			valid_s1  <= 1'b0;
			kind_s1   <= KIND_STOP;
			ch_s1     <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (valid_s1 && buf_free) begin
				valid_s1 <= 1'b0;
			end
			if (cmd_acc) begin
				unique case (op_t'(cmd.op))
					OP_TICK: begin
						if (running_q) begin
							if (!burst_en_q) begin
								phase_q  <= phase_next;
								kind_s1  <= KIND_CONT;
							end else if (ticks_q == 16'd0) begin
								running_q <= 1'b0;
							end else begin
								phase_q  <= phase_next;
								ticks_q  <= ticks_dec;
								kind_s1  <= KIND_BURST;
								ch_s1    <= burst_ch_q;
								if (ticks_dec == 16'd0) begin
									running_q <= 1'b0;
								end
							end
						end
					end
					OP_WRITE: ;
					OP_RUN: begin
						running_q <= 1'b1;
						ticks_q   <= burst_ticks_q;
					end
					OP_STOP: begin
						running_q <= 1'b0;
						kind_s1   <= KIND_STOP;
					end
				endcase
			end
		end
	end

	// words for the item in stage 1; w1 unused by a burst tick
	always_comb begin
		w0 = '0;
		w1 = '0;
		unique case (kind_s1)
			KIND_STOP: begin
				w0 = '{dac_word: 16'(idle_a_q) + CMD_A, dac_channel: 1'b0, last: 1'b0};
				w1 = '{dac_word: 16'(idle_b_q) + CMD_B, dac_channel: 1'b1, last: 1'b1};
			end
			KIND_CONT: begin
				w0 = '{dac_word: 16'(rd_a) + CMD_A, dac_channel: 1'b0, last: 1'b0};
				w1 = '{dac_word: 16'(rd_b) + CMD_B, dac_channel: 1'b1, last: 1'b1};
			end
			KIND_BURST: begin
				w0 = ch_s1 ?
					'{dac_word: 16'(rd_b) + CMD_B, dac_channel: 1'b1, last: 1'b1} :
					'{dac_word: 16'(rd_a) + CMD_A, dac_channel: 1'b0, last: 1'b1};
			end
			default: ;
		endcase
	end

	// output buffer: current word plus the second word of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_valid_q <= 1'b0;
			nxt_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && buf_free) begin
				dac_valid_q <= 1'b1;
				nxt_valid_q <= (kind_s1 != KIND_BURST);
			end else if (dac_acc) begin
				if (nxt_valid_q) begin
					nxt_valid_q <= 1'b0;
				end else begin
					dac_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && buf_free) begin
			dac_q <= w0;
			nxt_q <= w1;
		end else if (dac_acc && nxt_valid_q) begin
			dac_q <= nxt_q;
		end
	end

	assign dac_valid = dac_valid_q;
	assign dac       = dac_q;

endmodule
`default_nettype wire

/* hw/rtl/dcdds_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcdds_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dcdds_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dcdds_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcdds_checker
// Port-level checks of the DDS burst source, bound to the top level.
// ----------------------------------------------------------------------------
module dcdds_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 cmd_valid,
	input wire                                 cmd_stall,
	input dcdds_pkg::dds_cmd_t                 cmd,
	input wire                                 dac_valid,
	input wire                                 dac_stall,
	input dcdds_pkg::dds_dac_t                 dac
);

	import dcdds_pkg::*;

	// a stalled command holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("command changed while stalled");

	// a stalled word holds
	a_dac_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dac_valid && dac_stall |=> dac_valid && $stable(dac))
		else $error("DAC word changed while stalled");

	// first word of a pair is channel A
	a_first_is_a: assert property (@(posedge clk) disable iff (!arst_n)
		dac_valid && !dac.last |-> !dac.dac_channel)
		else $error("non-final word on channel B");

	// second word of a pair follows at once, channel B, marked last
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		dac_valid && !dac_stall && !dac.last |=>
		dac_valid && dac.dac_channel && dac.last)
		else $error("channel B word did not follow channel A word");

	// command nibble matches the channel
	a_cmd_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		dac_valid |-> (dac.dac_channel && (dac.dac_word[15:12] == CMD_B[15:12])) ||
		(!dac.dac_channel && (dac.dac_word[15:12] == CMD_A[15:12])))
		else $error("DAC command bits do not match channel");

endmodule

bind dual_channel_dds_burst dcdds_checker u_dcdds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.dac_valid (dac_valid),
	.dac_stall (dac_stall),
	.dac       (dac)
);
`default_nettype wire

/* dv/tb_dual_channel_dds_burst.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_channel_dds_burst
// Self-checking bench for the two-channel DDS source. A short table of
// directed commands, with DAC words typed in by hand, comes first. Random phases
// follow, each under its own register setting. A local copy of the accumulator,
// tables and burst counter predicts their words; a monitor checks every word in order.
// ----------------------------------------------------------------------------
module tb_dual_channel_dds_burst;
	import dcdds_pkg::*;

	localparam int ADDR_BITS       = $clog2(TABLE_DEPTH_DEF);
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 6;
	localparam int TAIL_CYCLES     = 20;
	localparam int CYCLE_LIMIT     = 800000;

	// indexes past the register list, writes there must be dropped
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_7 = 3'd7;

	typedef enum logic { ROW_CMD, ROW_CFG } row_kind_e;

	typedef struct {
		row_kind_e                 kind;
		dds_cmd_t                  cmd;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0]  data;
		bit                        fixed;
		int                        n_words;
		dds_dac_t                  w0;
		dds_dac_t                  w1;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_stall;
	dds_cmd_t                  cmd;
	logic                      dac_valid;
	logic                      dac_stall;
	dds_dac_t                  dac;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// predicted block state
	logic [PHASE_BITS_DEF-1:0] acc_phase   = '0;
	logic [31:0]               step        = '0;
	logic                      burst_mode  = 1'b0;
	logic                      burst_sel   = 1'b0;
	logic [15:0]               burst_len   = '0;
	logic [11:0]               idle_a      = IDLE_A_RST;
	logic [11:0]               idle_b      = IDLE_B_RST;
	logic                      run_flag    = 1'b0;
	logic [15:0]               ticks_to_go = '0;
	logic [11:0]               samp_a [TABLE_DEPTH_DEF];
	logic [11:0]               samp_b [TABLE_DEPTH_DEF];
	bit                        seen_a [TABLE_DEPTH_DEF];
	bit                        seen_b [TABLE_DEPTH_DEF];

	dds_dac_t dac_pending [$];
	dds_dac_t want;
	row_t     plan [$];
	bit       calm = 1'b0;
	int       errors = 0;
	int       cmd_count = 0;
	int       word_count = 0;
	int       cycle_count = 0;

	dual_channel_dds_burst uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.dac_valid (dac_valid),
		.dac_stall (dac_stall),
		.dac       (dac),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still expected", $time, dac_pending.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [ADDR_BITS-1:0] table_slot(logic [PHASE_BITS_DEF-1:0] ph);
		return ph[PHASE_BITS_DEF-1 -: ADDR_BITS];
	endfunction

	function automatic dds_dac_t dac_from_sample(logic [11:0] s, logic ch, logic lst);
		dds_dac_t d;
		d.dac_word    = {4'h0, s} + (ch ? CMD_B : CMD_A);
		d.dac_channel = ch;
		d.last        = lst;
		return d;
	endfunction

	function automatic logic [31:0] noisy(logic [31:0] v, int w);
		logic [31:0] m;
		m = (32'h1 << w) - 32'h1;
		return ($urandom & ~m) | (v & m);
	endfunction

	function automatic dds_cmd_t make_write(logic ch, logic [11:0] ix, logic [11:0] v);
		dds_cmd_t c;
		c.op            = OP_WRITE;
		c.table_channel = ch;
		c.table_index   = ix;
		c.table_value   = v;
		return c;
	endfunction

	function automatic row_t cmd_row(dds_cmd_t c);
		row_t r;
		r = '{kind: ROW_CMD, cmd: c, idx: '0, data: '0, fixed: 1'b0, n_words: 0,
			w0: '0, w1: '0};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] d);
		row_t r;
		r = '{kind: ROW_CFG, cmd: '0, idx: idx, data: d, fixed: 1'b0, n_words: 0,
			w0: '0, w1: '0};
		return r;
	endfunction

	// row whose DAC words are typed in by hand
	function automatic row_t fixed_row(op_t op, int n, dds_dac_t w0, dds_dac_t w1);
		row_t r;
		r = cmd_row('0);
		r.cmd.op  = op;
		r.fixed   = 1'b1;
		r.n_words = n;
		r.w0      = w0;
		r.w1      = w1;
		return r;
	endfunction

	task automatic synth_step(input dds_cmd_t c, input bit keep);
		logic [ADDR_BITS-1:0] slot;
		dds_dac_t             words [$];
		case (c.op)
			OP_WRITE: begin
				if (c.table_index < TABLE_DEPTH_DEF) begin
					if (c.table_channel) begin
						samp_b[c.table_index] = c.table_value;
						seen_b[c.table_index] = 1'b1;
					end else begin
						samp_a[c.table_index] = c.table_value;
						seen_a[c.table_index] = 1'b1;
					end
				end
			end
			OP_RUN: begin
				run_flag    = 1'b1;
				ticks_to_go = burst_len;
			end
			OP_STOP: begin
				run_flag = 1'b0;
				words.push_back(dac_from_sample(idle_a, 1'b0, 1'b0));
				words.push_back(dac_from_sample(idle_b, 1'b1, 1'b1));
			end
			OP_TICK: begin
				if (run_flag) begin
					if (burst_mode && ticks_to_go == 0) begin
						run_flag = 1'b0;
					end else begin
						acc_phase = acc_phase + step;
						slot = table_slot(acc_phase);
						if (burst_mode) begin
							words.push_back(dac_from_sample(burst_sel ? samp_b[slot] : samp_a[slot],
								burst_sel, 1'b1));
							ticks_to_go = ticks_to_go - 16'd1;
							if (ticks_to_go == 0)
								run_flag = 1'b0;
						end else begin
							words.push_back(dac_from_sample(samp_a[slot], 1'b0, 1'b0));
							words.push_back(dac_from_sample(samp_b[slot], 1'b1, 1'b1));
						end
					end
				end
			end
		endcase
		if (keep)
			foreach (words[i])
				dac_pending.push_back(words[i]);
	endtask

	task automatic send_cmd(input dds_cmd_t c, input bit keep);
		if (!calm && $urandom_range(0, 7) == 0) begin
			@(negedge clk) cmd_valid <= 1'b0;
			repeat ($urandom_range(0, 18)) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		synth_step(c, keep);
		cmd_count++;
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PHASE_INC:   step       = d;
			REG_BURST_EN:    burst_mode = d[0];
			REG_BURST_CH:    burst_sel  = d[0];
			REG_BURST_TICKS: burst_len  = d[15:0];
			REG_IDLE_A:      idle_a     = d[11:0];
			REG_IDLE_B:      idle_b     = d[11:0];
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// hold off commands until every word is out and the pipe is quiet
	task automatic drain();
		@(negedge clk) cmd_valid <= 1'b0;
		while (dac_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// make sure the entry the next tick reads has been written
	task automatic fill_ahead();
		logic [ADDR_BITS-1:0] slot;
		if (run_flag && (!burst_mode || ticks_to_go != 0)) begin
			slot = table_slot(acc_phase + step);
			if (!seen_a[slot])
				send_cmd(make_write(1'b0, 12'(slot), 12'($urandom)), 1'b1);
			if (!seen_b[slot])
				send_cmd(make_write(1'b1, 12'(slot), 12'($urandom)), 1'b1);
		end
	endtask

	task automatic report_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && dac_valid && !dac_stall) begin
			if (dac_pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected DAC word, expected none, actual %h ch %b last %b",
					$time, dac.dac_word, dac.dac_channel, dac.last);
			end else begin
				want = dac_pending.pop_front();
				word_count++;
				if (dac.dac_word !== want.dac_word)
					report_field("dac_word", want.dac_word, dac.dac_word);
				if (dac.dac_channel !== want.dac_channel)
					report_field("dac_channel", 16'(want.dac_channel), 16'(dac.dac_channel));
				if (dac.last !== want.last)
					report_field("last", 16'(want.last), 16'(dac.last));
			end
		end
	end

	// output back-pressure: short bursts, with quiet stretches between
	initial begin
		dac_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 15) == 0) begin
				dac_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				dac_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
		end
	end

	initial begin
		dds_cmd_t    c;
		logic [31:0] inc_v;
		logic [15:0] len_v;
		int          r;
		int          phase_end;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		// reset values, table extremes, run while running, burst end, idle codes
		plan.push_back(fixed_row(OP_STOP, 2, dds_dac_t'{16'h37CC, 1'b0, 1'b0},
			dds_dac_t'{16'hB7DA, 1'b1, 1'b1}));
		plan.push_back(fixed_row(OP_TICK, 0, '0, '0));
		plan.push_back(cmd_row(make_write(1'b0, 12'h000, 12'hFFF)));
		plan.push_back(cmd_row(make_write(1'b1, 12'h000, 12'h000)));
		plan.push_back(cmd_row(make_write(1'b0, 12'hFFF, 12'h000)));
		plan.push_back(cmd_row(make_write(1'b1, 12'hFFF, 12'hFFF)));
		plan.push_back(fixed_row(OP_RUN, 0, '0, '0));
		plan.push_back(fixed_row(OP_TICK, 2, dds_dac_t'{16'h3FFF, 1'b0, 1'b0},
			dds_dac_t'{16'hB000, 1'b1, 1'b1}));
		plan.push_back(fixed_row(OP_RUN, 0, '0, '0));
		plan.push_back(cfg_row(REG_PHASE_INC, 32'hFFFF_FFFF));
		plan.push_back(fixed_row(OP_TICK, 2, dds_dac_t'{16'h3000, 1'b0, 1'b0},
			dds_dac_t'{16'hBFFF, 1'b1, 1'b1}));
		plan.push_back(cfg_row(REG_BURST_EN, 32'd1));
		plan.push_back(cfg_row(REG_BURST_CH, 32'd1));
		plan.push_back(cfg_row(REG_BURST_TICKS, 32'd2));
		plan.push_back(fixed_row(OP_RUN, 0, '0, '0));
		plan.push_back(fixed_row(OP_TICK, 1, dds_dac_t'{16'hBFFF, 1'b1, 1'b1}, '0));
		plan.push_back(fixed_row(OP_TICK, 1, dds_dac_t'{16'hBFFF, 1'b1, 1'b1}, '0));
		plan.push_back(fixed_row(OP_TICK, 0, '0, '0));
		plan.push_back(cfg_row(REG_BURST_TICKS, 32'd0));
		plan.push_back(fixed_row(OP_RUN, 0, '0, '0));
		plan.push_back(fixed_row(OP_TICK, 0, '0, '0));
		plan.push_back(fixed_row(OP_TICK, 0, '0, '0));
		plan.push_back(cfg_row(REG_IDLE_A, 32'h0000_0FFF));
		plan.push_back(cfg_row(REG_IDLE_B, 32'h0000_0000));
		plan.push_back(cfg_row(CFG_SPARE_6, 32'hFFFF_FFFF));
		plan.push_back(fixed_row(OP_STOP, 2, dds_dac_t'{16'h3FFF, 1'b0, 1'b0},
			dds_dac_t'{16'hB000, 1'b1, 1'b1}));

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				cfg_write(plan[i].idx, plan[i].data);
			end else begin
				send_cmd(plan[i].cmd, !plan[i].fixed);
				if (plan[i].fixed && plan[i].n_words > 0)
					dac_pending.push_back(plan[i].w0);
				if (plan[i].fixed && plan[i].n_words > 1)
					dac_pending.push_back(plan[i].w1);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			calm = (p == NUM_PHASES - 1);
			case (p % 6)
				0: inc_v = 32'h0;
				1: inc_v = 32'hFFFF_FFFF;
				2: inc_v = 32'h1;
				3: inc_v = 32'h0010_0000;
				4: inc_v = $urandom;
				default: inc_v = $urandom_range(1, 32'h00FF_FFFF);
			endcase
			case (p)
				2: len_v = 16'd0;
				3: len_v = 16'hFFFF;
				6: len_v = 16'd1;
				default: len_v = 16'($urandom_range(1, 40));
			endcase
			cfg_write(REG_PHASE_INC, inc_v);
			cfg_write(REG_BURST_EN, noisy(32'((p / 2) % 2), 1));
			cfg_write(REG_BURST_CH, noisy(32'(p % 2), 1));
			cfg_write(REG_BURST_TICKS, noisy(32'(len_v), 16));
			case (p % 3)
				0: begin
					cfg_write(REG_IDLE_A, noisy(32'h0, 12));
					cfg_write(REG_IDLE_B, noisy(32'hFFF, 12));
				end
				1: begin
					cfg_write(REG_IDLE_A, noisy(32'hFFF, 12));
					cfg_write(REG_IDLE_B, noisy(32'h0, 12));
				end
				default: begin
					cfg_write(REG_IDLE_A, $urandom);
					cfg_write(REG_IDLE_B, $urandom);
				end
			endcase
			cfg_write((p % 2) ? CFG_SPARE_7 : CFG_SPARE_6, $urandom);

			// table fills count toward the phase budget
			phase_end = cmd_count + ITEMS_PER_PHASE;
			while (cmd_count < phase_end) begin
				c = dds_cmd_t'($urandom);
				r = $urandom_range(0, 99);
				if (r < 64)
					c.op = OP_TICK;
				else if (r < 80)
					c.op = OP_WRITE;
				else if (r < 92)
					c.op = OP_RUN;
				else
					c.op = OP_STOP;
				// mostly restart a stopped source rather than tick into nothing
				if (!run_flag && c.op == OP_TICK && $urandom_range(0, 3) != 0)
					c.op = OP_RUN;
				if (c.op == OP_TICK)
					fill_ahead();
				send_cmd(c, 1'b1);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d commands over %0d register settings, %0d DAC words checked.",
			cmd_count, NUM_PHASES + 1, word_count);
		$display("Covered continuous and burst ticks, table writes, run reloads and stops.");
		if (errors == 0 && dac_pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
